// ===== rtl/cpe_pkg.sv =====
package cpe_pkg;

  // Number format and field widths
  localparam int FRAC_BITS = 8;
  localparam int POS_W     = 24;
  localparam int RAD_W     = 20;
  localparam int MASS_W    = 16;

  // Square root: a colliding pair has s below (2^(RAD_W+1))^2
  localparam int ROOT_W   = RAD_W + 1;
  localparam int RAD_SQ_W = 2 * ROOT_W;
  localparam int SQRT_LAT = ROOT_W;

  // Rounding divider, common to every divider instance
  localparam int DIV_NUM_W = 52;
  localparam int DIV_DEN_W = 22;
  localparam int DIV_QUO_W = 30;
  localparam int DIV_LAT   = DIV_QUO_W + 2;

  localparam int NORM_W = 22;

  localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1) << FRAC_BITS;
  localparam logic [ROOT_W-1:0]         DN_ONE   = ROOT_W'(1) << FRAC_BITS;
  localparam logic [DIV_DEN_W-1:0]      DEN_ONE  = DIV_DEN_W'(1);

  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef struct packed {
    logic                    collided;
    logic signed [POS_W-1:0] new_first_pos_x;
    logic signed [POS_W-1:0] new_first_pos_y;
    logic signed [POS_W-1:0] new_first_vel_x;
    logic signed [POS_W-1:0] new_first_vel_y;
    logic signed [POS_W-1:0] new_second_pos_x;
    logic signed [POS_W-1:0] new_second_pos_y;
    logic signed [POS_W-1:0] new_second_vel_x;
    logic signed [POS_W-1:0] new_second_vel_y;
  } res_t;

  // Clamp a 32-bit sum into the signed position range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [31:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 32'(POS_MAX)) begin
      r = POS_MAX;
    end else if (v < 32'(POS_MIN)) begin
      r = POS_MIN;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/cpe_if.sv =====
interface cpe_in_if import cpe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] first_pos_x;
  logic signed [POS_W-1:0] first_pos_y;
  logic signed [POS_W-1:0] first_vel_x;
  logic signed [POS_W-1:0] first_vel_y;
  logic [RAD_W-1:0]        first_radius;
  logic [MASS_W-1:0]       first_mass;
  logic signed [POS_W-1:0] second_pos_x;
  logic signed [POS_W-1:0] second_pos_y;
  logic signed [POS_W-1:0] second_vel_x;
  logic signed [POS_W-1:0] second_vel_y;
  logic [RAD_W-1:0]        second_radius;
  logic [MASS_W-1:0]       second_mass;

  modport source (
    output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
           first_mass, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
           second_radius, second_mass,
    input  ready
  );
  modport sink (
    input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
           first_mass, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
           second_radius, second_mass,
    output ready
  );
endinterface

interface cpe_out_if import cpe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    collided;
  logic signed [POS_W-1:0] new_first_pos_x;
  logic signed [POS_W-1:0] new_first_pos_y;
  logic signed [POS_W-1:0] new_first_vel_x;
  logic signed [POS_W-1:0] new_first_vel_y;
  logic signed [POS_W-1:0] new_second_pos_x;
  logic signed [POS_W-1:0] new_second_pos_y;
  logic signed [POS_W-1:0] new_second_vel_x;
  logic signed [POS_W-1:0] new_second_vel_y;

  modport source (
    output valid, collided, new_first_pos_x, new_first_pos_y, new_first_vel_x,
           new_first_vel_y, new_second_pos_x, new_second_pos_y, new_second_vel_x,
           new_second_vel_y,
    input  ready
  );
  modport sink (
    input  valid, collided, new_first_pos_x, new_first_pos_y, new_first_vel_x,
           new_first_vel_y, new_second_pos_x, new_second_pos_y, new_second_vel_x,
           new_second_vel_y,
    output ready
  );
endinterface

// ===== rtl/cpe_sqrt.sv =====
module cpe_sqrt import cpe_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [RAD_SQ_W-1:0] s_i,
  output logic [ROOT_W-1:0]   root_o
);

  localparam int REM_W = ROOT_W + 2;

  logic [RAD_SQ_W-1:0] rad_q  [ROOT_W];
  logic [RAD_SQ_W-1:0] rad_d  [ROOT_W];
  logic [REM_W-1:0]    rem_q  [ROOT_W];
  logic [REM_W-1:0]    rem_d  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [ROOT_W-1:0]   root_d [ROOT_W];

  // One root bit per stage: bring down two radicand bits, try (4*root + 1)
  always_comb begin
    logic [RAD_SQ_W-1:0] rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
    logic [REM_W+1:0]    part;
    logic [REM_W+1:0]    trial;
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        rad  = s_i;
        rem  = '0;
        root = '0;
      end else begin
        rad  = rad_q[k-1];
        rem  = rem_q[k-1];
        root = root_q[k-1];
      end
      part  = {rem, rad[RAD_SQ_W-1 -: 2]};
      trial = {2'b00, root, 2'b01};
      if (part >= trial) begin
        rem_d[k]  = REM_W'(part - trial);
        root_d[k] = {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = REM_W'(part);
        root_d[k] = {root[ROOT_W-2:0], 1'b0};
      end
      rad_d[k] = {rad[RAD_SQ_W-3:0], 2'b00};
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

// ===== rtl/cpe_div.sv =====
module cpe_div import cpe_pkg::*; (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0]        den_i,
  output logic signed [DIV_QUO_W:0]   q_o
);

  logic                 neg_q [DIV_QUO_W+1];
  logic [DIV_DEN_W-1:0] den_q [DIV_QUO_W+1];
  logic [DIV_NUM_W-1:0] rem_q [DIV_QUO_W+1];
  logic [DIV_QUO_W-1:0] quo_q [DIV_QUO_W+1];
  logic [DIV_NUM_W-1:0] rem_d [DIV_QUO_W];
  logic [DIV_QUO_W-1:0] quo_d [DIV_QUO_W];
  logic [DIV_NUM_W-1:0] mag;
  logic signed [DIV_QUO_W:0] q_q;

  // Magnitude plus half the divisor gives round to nearest, ties away from zero
  always_comb begin
    if (num_i[DIV_NUM_W-1]) begin
      mag = DIV_NUM_W'(-num_i);
    end else begin
      mag = DIV_NUM_W'(num_i);
    end
  end

  // Restoring steps, one quotient bit per stage from the top
  always_comb begin
    logic [DIV_NUM_W-1:0] t;
    for (int k = 0; k < DIV_QUO_W; k++) begin
      t        = DIV_NUM_W'(den_q[k]) << (DIV_QUO_W - 1 - k);
      quo_d[k] = quo_q[k];
      if (rem_q[k] >= t) begin
        rem_d[k] = rem_q[k] - t;
        quo_d[k][DIV_QUO_W-1-k] = 1'b1;
      end else begin
        rem_d[k] = rem_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= num_i[DIV_NUM_W-1];
      den_q[0] <= den_i;
      rem_q[0] <= mag + DIV_NUM_W'(den_i >> 1);
      quo_q[0] <= '0;
      for (int k = 0; k < DIV_QUO_W; k++) begin
        neg_q[k+1] <= neg_q[k];
        den_q[k+1] <= den_q[k];
        rem_q[k+1] <= rem_d[k];
        quo_q[k+1] <= quo_d[k];
      end
      // Restore the sign
      if (neg_q[DIV_QUO_W]) begin
        q_q <= -$signed({1'b0, quo_q[DIV_QUO_W]});
      end else begin
        q_q <= $signed({1'b0, quo_q[DIV_QUO_W]});
      end
    end
  end

  assign q_o = q_q;

endmodule

// ===== rtl/circle_pair_elastic_collision.sv =====
// Two-circle elastic collision resolver.
// Input channel in_i carries one body pair per transaction: center, velocity,
// radius and mass of each circle. Output channel out_o carries one result per
// transaction: the collided flag and both bodies' new centers and velocities.
// Pairs that do not touch come back unchanged with collided clear.
// Both channels use a valid/ready handshake; a transaction moves when both
// are high at a rising clock edge.
// Throughput: one pair per cycle while the output buffer has room. The depth
// is set by the 21-stage square root and three banks of 32-stage rounding
// dividers (normal projection and push, elastic exchange, velocity correction),
// each square-root stage and each divider step retiring one result bit.
// A two-entry output buffer sits behind the pipeline; in_i.ready depends only
// on its fill, so input keeps flowing while one result waits. When the buffer
// is full the whole pipeline holds and in_i.ready drops; nothing is lost.
// Reset (rst_ni low, asynchronous) empties the pipeline and the buffer.
module circle_pair_elastic_collision import cpe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpe_in_if.sink    in_i,
  cpe_out_if.source out_o
);

  typedef struct packed {
    logic signed [POS_W-1:0]  p1x;
    logic signed [POS_W-1:0]  p1y;
    logic signed [POS_W-1:0]  v1x;
    logic signed [POS_W-1:0]  v1y;
    logic signed [POS_W-1:0]  p2x;
    logic signed [POS_W-1:0]  p2y;
    logic signed [POS_W-1:0]  v2x;
    logic signed [POS_W-1:0]  v2y;
    logic [MASS_W-1:0]        m1;
    logic [MASS_W-1:0]        m2;
    logic signed [POS_W:0]    dx;
    logic signed [POS_W:0]    dy;
    logic [ROOT_W-1:0]        rsum;
    logic [2*POS_W:0]         dx2;
    logic [2*POS_W:0]         dy2;
    logic [RAD_SQ_W-1:0]      rsq;
    logic [2*POS_W+1:0]       s;
    logic                     hit;
    logic signed [NORM_W-1:0] ndx;
    logic signed [NORM_W-1:0] ndy;
    logic [ROOT_W-1:0]        dn;
    logic [ROOT_W-1:0]        ov;
    logic signed [45:0]       pa;
    logic signed [45:0]       pb;
    logic signed [45:0]       pc;
    logic signed [45:0]       pd;
    logic signed [43:0]       sa;
    logic signed [43:0]       sb;
    logic signed [46:0]       pv1;
    logic signed [46:0]       pv2;
    logic signed [26:0]       u1;
    logic signed [26:0]       u2;
    logic signed [22:0]       shx;
    logic signed [22:0]       shy;
    logic [MASS_W:0]          msum;
    logic signed [45:0]       e1a;
    logic signed [45:0]       e1b;
    logic signed [45:0]       e2a;
    logic signed [45:0]       e2b;
    logic signed [46:0]       n1;
    logic signed [46:0]       n2;
    logic signed [28:0]       dv1;
    logic signed [28:0]       dv2;
    logic signed [50:0]       c1x;
    logic signed [50:0]       c1y;
    logic signed [50:0]       c2x;
    logic signed [50:0]       c2y;
  } item_t;

  logic       en;
  logic [1:0] cnt_q;
  logic       wr_q, rd_q;
  logic       push, pop;
  res_t       fifo_q [2];

  item_t s1_q, s1_d, s2_q, s2_d, s3_q, s3_d, s4_q, s4_d, s5_q, s5_d, s6_q, s6_d;
  item_t s7_q, s7_d, s8_q, s8_d, s9_q, s9_d, s10_q, s10_d;
  res_t  r11_q, r11_d;
  logic  v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q;

  item_t sq_q [SQRT_LAT];
  item_t da_q [DIV_LAT];
  item_t db_q [DIV_LAT];
  item_t dc_q [DIV_LAT];
  logic [SQRT_LAT-1:0] sqv_q;
  logic [DIV_LAT-1:0]  dav_q, dbv_q, dcv_q;

  logic [ROOT_W-1:0]        root;
  logic signed [DIV_QUO_W:0] qa [4];
  logic signed [DIV_QUO_W:0] qb [2];
  logic signed [DIV_QUO_W:0] qc [4];
  logic [DIV_DEN_W-1:0]     den_dn6, den_2dn6, den_m8, den_dn10;

  // The whole pipeline moves while the output buffer has room
  assign en        = (cnt_q != 2'd2);
  assign in_i.ready = en;

  // Stage 1: center offset and radius sum
  always_comb begin
    s1_d      = '0;
    s1_d.p1x  = in_i.first_pos_x;
    s1_d.p1y  = in_i.first_pos_y;
    s1_d.v1x  = in_i.first_vel_x;
    s1_d.v1y  = in_i.first_vel_y;
    s1_d.p2x  = in_i.second_pos_x;
    s1_d.p2y  = in_i.second_pos_y;
    s1_d.v2x  = in_i.second_vel_x;
    s1_d.v2y  = in_i.second_vel_y;
    s1_d.m1   = in_i.first_mass;
    s1_d.m2   = in_i.second_mass;
    s1_d.dx   = (POS_W+1)'(in_i.second_pos_x) - (POS_W+1)'(in_i.first_pos_x);
    s1_d.dy   = (POS_W+1)'(in_i.second_pos_y) - (POS_W+1)'(in_i.first_pos_y);
    s1_d.rsum = {1'b0, in_i.first_radius} + {1'b0, in_i.second_radius};
  end

  // Stage 2: squares
  always_comb begin
    logic signed [2*POS_W+1:0] px;
    logic signed [2*POS_W+1:0] py;
    s2_d     = s1_q;
    px       = s1_q.dx * s1_q.dx;
    py       = s1_q.dy * s1_q.dy;
    s2_d.dx2 = px[2*POS_W:0];
    s2_d.dy2 = py[2*POS_W:0];
    s2_d.rsq = s1_q.rsum * s1_q.rsum;
  end

  // Stage 3: squared distance and contact test
  always_comb begin
    s3_d     = s2_q;
    s3_d.s   = {1'b0, s2_q.dx2} + {1'b0, s2_q.dy2};
    s3_d.hit = (s3_d.s <= (2*POS_W+2)'(s2_q.rsq));
  end

  cpe_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (s3_q.s[RAD_SQ_W-1:0]),
    .root_o (root)
  );

  // Stage 4: distance, overlap and normal; coincident centers use (1, 0)
  always_comb begin
    s4_d    = sq_q[SQRT_LAT-1];
    s4_d.ov = s4_d.rsum - root;
    if (root == '0) begin
      s4_d.ndx = NORM_ONE;
      s4_d.ndy = '0;
      s4_d.dn  = DN_ONE;
    end else begin
      s4_d.ndx = s4_d.dx[NORM_W-1:0];
      s4_d.ndy = s4_d.dy[NORM_W-1:0];
      s4_d.dn  = root;
    end
  end

  // Stage 5: projection and push products
  always_comb begin
    s5_d    = s4_q;
    s5_d.pa = s4_q.v1x * s4_q.ndx;
    s5_d.pb = s4_q.v1y * s4_q.ndy;
    s5_d.pc = s4_q.v2x * s4_q.ndx;
    s5_d.pd = s4_q.v2y * s4_q.ndy;
    s5_d.sa = s4_q.ndx * $signed({1'b0, s4_q.ov});
    s5_d.sb = s4_q.ndy * $signed({1'b0, s4_q.ov});
  end

  // Stage 6: dot products
  always_comb begin
    s6_d     = s5_q;
    s6_d.pv1 = 47'(s5_q.pa) + 47'(s5_q.pb);
    s6_d.pv2 = 47'(s5_q.pc) + 47'(s5_q.pd);
  end

  assign den_dn6  = {1'b0, s6_q.dn};
  assign den_2dn6 = {s6_q.dn, 1'b0};

  cpe_div u_div_u1 (.clk_i(clk_i), .en_i(en), .num_i(DIV_NUM_W'(s6_q.pv1)),
                    .den_i(den_dn6), .q_o(qa[0]));
  cpe_div u_div_u2 (.clk_i(clk_i), .en_i(en), .num_i(DIV_NUM_W'(s6_q.pv2)),
                    .den_i(den_dn6), .q_o(qa[1]));
  cpe_div u_div_shx (.clk_i(clk_i), .en_i(en), .num_i(DIV_NUM_W'(s6_q.sa)),
                     .den_i(den_2dn6), .q_o(qa[2]));
  cpe_div u_div_shy (.clk_i(clk_i), .en_i(en), .num_i(DIV_NUM_W'(s6_q.sb)),
                     .den_i(den_2dn6), .q_o(qa[3]));

  // Stage 7: elastic exchange products
  always_comb begin
    logic signed [MASS_W:0]   md;
    logic signed [MASS_W:0]   md2;
    logic signed [MASS_W+2:0] m1x2;
    logic signed [MASS_W+2:0] m2x2;
    s7_d      = da_q[DIV_LAT-1];
    s7_d.u1   = qa[0][26:0];
    s7_d.u2   = qa[1][26:0];
    s7_d.shx  = qa[2][22:0];
    s7_d.shy  = qa[3][22:0];
    md        = {1'b0, s7_d.m1} - {1'b0, s7_d.m2};
    md2       = {1'b0, s7_d.m2} - {1'b0, s7_d.m1};
    m1x2      = {1'b0, s7_d.m1, 1'b0};
    m2x2      = {1'b0, s7_d.m2, 1'b0};
    s7_d.msum = {1'b0, s7_d.m1} + {1'b0, s7_d.m2};
    s7_d.e1a  = md * s7_d.u1;
    s7_d.e1b  = m2x2 * s7_d.u2;
    s7_d.e2a  = md2 * s7_d.u2;
    s7_d.e2b  = m1x2 * s7_d.u1;
  end

  // Stage 8: elastic numerators
  always_comb begin
    s8_d    = s7_q;
    s8_d.n1 = 47'(s7_q.e1a) + 47'(s7_q.e1b);
    s8_d.n2 = 47'(s7_q.e2a) + 47'(s7_q.e2b);
  end

  assign den_m8 = (s8_q.msum == '0) ? DEN_ONE : DIV_DEN_W'(s8_q.msum);

  cpe_div u_div_w1 (.clk_i(clk_i), .en_i(en), .num_i(DIV_NUM_W'(s8_q.n1)),
                    .den_i(den_m8), .q_o(qb[0]));
  cpe_div u_div_w2 (.clk_i(clk_i), .en_i(en), .num_i(DIV_NUM_W'(s8_q.n2)),
                    .den_i(den_m8), .q_o(qb[1]));

  // Stage 9: normal velocity change; massless pair keeps its velocities
  always_comb begin
    s9_d = db_q[DIV_LAT-1];
    if (s9_d.msum == '0) begin
      s9_d.dv1 = '0;
      s9_d.dv2 = '0;
    end else begin
      s9_d.dv1 = 29'($signed(qb[0][27:0])) - 29'(s9_d.u1);
      s9_d.dv2 = 29'($signed(qb[1][27:0])) - 29'(s9_d.u2);
    end
  end

  // Stage 10: velocity correction products
  always_comb begin
    s10_d     = s9_q;
    s10_d.c1x = s9_q.ndx * s9_q.dv1;
    s10_d.c1y = s9_q.ndy * s9_q.dv1;
    s10_d.c2x = s9_q.ndx * s9_q.dv2;
    s10_d.c2y = s9_q.ndy * s9_q.dv2;
  end

  assign den_dn10 = {1'b0, s10_q.dn};

  cpe_div u_div_c1x (.clk_i(clk_i), .en_i(en), .num_i(DIV_NUM_W'(s10_q.c1x)),
                     .den_i(den_dn10), .q_o(qc[0]));
  cpe_div u_div_c1y (.clk_i(clk_i), .en_i(en), .num_i(DIV_NUM_W'(s10_q.c1y)),
                     .den_i(den_dn10), .q_o(qc[1]));
  cpe_div u_div_c2x (.clk_i(clk_i), .en_i(en), .num_i(DIV_NUM_W'(s10_q.c2x)),
                     .den_i(den_dn10), .q_o(qc[2]));
  cpe_div u_div_c2y (.clk_i(clk_i), .en_i(en), .num_i(DIV_NUM_W'(s10_q.c2y)),
                     .den_i(den_dn10), .q_o(qc[3]));

  // Stage 11: apply push and velocity change, saturate; echo when apart
  always_comb begin
    item_t it;
    it = dc_q[DIV_LAT-1];
    if (it.hit) begin
      r11_d.collided         = 1'b1;
      r11_d.new_first_pos_x  = sat_pos(32'(it.p1x) - 32'(it.shx));
      r11_d.new_first_pos_y  = sat_pos(32'(it.p1y) - 32'(it.shy));
      r11_d.new_first_vel_x  = sat_pos(32'(it.v1x) + 32'(qc[0]));
      r11_d.new_first_vel_y  = sat_pos(32'(it.v1y) + 32'(qc[1]));
      r11_d.new_second_pos_x = sat_pos(32'(it.p2x) + 32'(it.shx));
      r11_d.new_second_pos_y = sat_pos(32'(it.p2y) + 32'(it.shy));
      r11_d.new_second_vel_x = sat_pos(32'(it.v2x) + 32'(qc[2]));
      r11_d.new_second_vel_y = sat_pos(32'(it.v2y) + 32'(qc[3]));
    end else begin
      r11_d.collided         = 1'b0;
      r11_d.new_first_pos_x  = it.p1x;
      r11_d.new_first_pos_y  = it.p1y;
      r11_d.new_first_vel_x  = it.v1x;
      r11_d.new_first_vel_y  = it.v1y;
      r11_d.new_second_pos_x = it.p2x;
      r11_d.new_second_pos_y = it.p2y;
      r11_d.new_second_vel_x = it.v2x;
      r11_d.new_second_vel_y = it.v2y;
    end
  end

  // Advance payload of all stages and side lines together
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      s4_q  <= s4_d;
      s5_q  <= s5_d;
      s6_q  <= s6_d;
      s7_q  <= s7_d;
      s8_q  <= s8_d;
      s9_q  <= s9_d;
      s10_q <= s10_d;
      r11_q <= r11_d;
      sq_q[0] <= s3_q;
      for (int k = 1; k < SQRT_LAT; k++) begin
        sq_q[k] <= sq_q[k-1];
      end
      da_q[0] <= s6_q;
      db_q[0] <= s8_q;
      dc_q[0] <= s10_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        da_q[k] <= da_q[k-1];
        db_q[k] <= db_q[k-1];
        dc_q[k] <= dc_q[k-1];
      end
    end
  end

  // Valid bits travel with the payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      sqv_q <= '0;
      dav_q <= '0;
      dbv_q <= '0;
      dcv_q <= '0;
    end else if (en) begin
      v1_q  <= in_i.valid;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      sqv_q <= {sqv_q[SQRT_LAT-2:0], v3_q};
      v4_q  <= sqv_q[SQRT_LAT-1];
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      dav_q <= {dav_q[DIV_LAT-2:0], v6_q};
      v7_q  <= dav_q[DIV_LAT-1];
      v8_q  <= v7_q;
      dbv_q <= {dbv_q[DIV_LAT-2:0], v8_q};
      v9_q  <= dbv_q[DIV_LAT-1];
      v10_q <= v9_q;
      dcv_q <= {dcv_q[DIV_LAT-2:0], v10_q};
      v11_q <= dcv_q[DIV_LAT-1];
    end
  end

  // Output buffer: two entries between the pipeline and the receiver
  assign push = en && v11_q;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= r11_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign out_o.valid            = (cnt_q != 2'd0);
  assign out_o.collided         = fifo_q[rd_q].collided;
  assign out_o.new_first_pos_x  = fifo_q[rd_q].new_first_pos_x;
  assign out_o.new_first_pos_y  = fifo_q[rd_q].new_first_pos_y;
  assign out_o.new_first_vel_x  = fifo_q[rd_q].new_first_vel_x;
  assign out_o.new_first_vel_y  = fifo_q[rd_q].new_first_vel_y;
  assign out_o.new_second_pos_x = fifo_q[rd_q].new_second_pos_x;
  assign out_o.new_second_pos_y = fifo_q[rd_q].new_second_pos_y;
  assign out_o.new_second_vel_x = fifo_q[rd_q].new_second_vel_x;
  assign out_o.new_second_vel_y = fifo_q[rd_q].new_second_vel_y;

`ifndef SYNTHESIS
  // A touching pair never has a distance beyond its radius sum
  a_root_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqv_q[SQRT_LAT-1] && sq_q[SQRT_LAT-1].hit |-> root <= sq_q[SQRT_LAT-1].rsum)
    else $error("square root exceeds radius sum on a touching pair");

  // A held pipeline keeps its last stage
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v11_q))
    else $error("last stage changed while the pipeline was held");

  // The buffer is never written while full and not drained
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> cnt_q != 2'd2)
    else $error("output buffer overflow");
`endif

endmodule

// ===== tb/tb_circle_pair_elastic_collision.sv =====
`timescale 1ns / 1ps

module tb_circle_pair_elastic_collision;
  import cpe_pkg::*;

  localparam int LATENCY     = 128;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int N_RANDOM    = 1030;

  typedef struct {
    logic signed [POS_W-1:0] p1x, p1y, v1x, v1y;
    logic [RAD_W-1:0]        r1;
    logic [MASS_W-1:0]       m1;
    logic signed [POS_W-1:0] p2x, p2y, v2x, v2y;
    logic [RAD_W-1:0]        r2;
    logic [MASS_W-1:0]       m2;
  } pair_t;

  // Directed row: a pair, and a result typed in where obvious
  typedef struct {
    pair_t pair;
    bit    literal;
    res_t  res;
  } row_t;

  logic clk_i;
  logic rst_ni;

  cpe_in_if  in_if ();
  cpe_out_if out_if ();

  circle_pair_elastic_collision uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  res_t  collision_results_q[$];
  int    errors;
  int    cycle_count;
  int    send_idle_pct;
  int    recv_stall_pct;
  bit    hold_off;
  bit    hold_off_req;
  row_t  rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Nearest, ties away from zero; den > 0
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp24(longint v);
    if (v > 64'sd8388607) return POS_MAX;
    if (v < -64'sd8388608) return POS_MIN;
    return v[POS_W-1:0];
  endfunction

  function automatic longint root_floor(longint n);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = 64'd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic res_t resolve_collision(pair_t p);
    res_t   r;
    longint dx, dy, s, rsum, d, ovl, u1, u2, ms, w1, w2, dv1, dv2, shx, shy;
    longint m1, m2;
    dx   = longint'(p.p2x) - longint'(p.p1x);
    dy   = longint'(p.p2y) - longint'(p.p1y);
    s    = dx * dx + dy * dy;
    rsum = longint'(p.r1) + longint'(p.r2);
    if (s > rsum * rsum) begin
      r = '{1'b0, p.p1x, p.p1y, p.v1x, p.v1y, p.p2x, p.p2y, p.v2x, p.v2y};
      return r;
    end
    d   = root_floor(s);
    ovl = rsum - d;
    // Coincident centers push along x
    if (d == 0) begin
      dx = 64'sd1 <<< FRAC_BITS;
      dy = 0;
      d  = 64'sd1 <<< FRAC_BITS;
    end
    m1 = longint'(p.m1);
    m2 = longint'(p.m2);
    u1 = round_div(longint'(p.v1x) * dx + longint'(p.v1y) * dy, d);
    u2 = round_div(longint'(p.v2x) * dx + longint'(p.v2y) * dy, d);
    ms = m1 + m2;
    w1 = u1;
    w2 = u2;
    if (ms != 0) begin
      w1 = round_div((m1 - m2) * u1 + 2 * m2 * u2, ms);
      w2 = round_div((m2 - m1) * u2 + 2 * m1 * u1, ms);
    end
    dv1 = w1 - u1;
    dv2 = w2 - u2;
    shx = round_div(dx * ovl, 2 * d);
    shy = round_div(dy * ovl, 2 * d);
    r.collided         = 1'b1;
    r.new_first_pos_x  = clamp24(longint'(p.p1x) - shx);
    r.new_first_pos_y  = clamp24(longint'(p.p1y) - shy);
    r.new_first_vel_x  = clamp24(longint'(p.v1x) + round_div(dx * dv1, d));
    r.new_first_vel_y  = clamp24(longint'(p.v1y) + round_div(dy * dv1, d));
    r.new_second_pos_x = clamp24(longint'(p.p2x) + shx);
    r.new_second_pos_y = clamp24(longint'(p.p2y) + shy);
    r.new_second_vel_x = clamp24(longint'(p.v2x) + round_div(dx * dv2, d));
    r.new_second_vel_y = clamp24(longint'(p.v2y) + round_div(dy * dv2, d));
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] rand_coord(int span);
    case ($urandom_range(0, 3))
      0:       return POS_W'($urandom);
      default: return POS_W'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  // Mostly touching pairs near each other, some far apart or extreme
  function automatic pair_t rand_pair();
    pair_t p;
    int    span;
    int    kind;
    kind = $urandom_range(0, 9);
    span = (kind < 5) ? 4096 : 1 << $urandom_range(8, 23);
    p.p1x = rand_coord(span);
    p.p1y = rand_coord(span);
    p.v1x = POS_W'($urandom);
    p.v1y = POS_W'($urandom);
    p.p2x = (kind < 7) ? p.p1x + POS_W'($signed($urandom_range(0, 2 * span)) - span)
                       : POS_W'($urandom);
    p.p2y = (kind < 7) ? p.p1y + POS_W'($signed($urandom_range(0, 2 * span)) - span)
                       : POS_W'($urandom);
    p.v2x = POS_W'($urandom);
    p.v2y = POS_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      p.r1 = RAD_W'($urandom);
      p.r2 = RAD_W'($urandom);
    end else begin
      p.r1 = RAD_W'($urandom_range(0, 4 * span));
      p.r2 = RAD_W'($urandom_range(0, 4 * span));
    end
    p.m1 = ($urandom_range(0, 7) == 0) ? MASS_W'($urandom_range(0, 1)) : MASS_W'($urandom);
    p.m2 = ($urandom_range(0, 7) == 0) ? MASS_W'($urandom_range(0, 1)) : MASS_W'($urandom);
    if ($urandom_range(0, 15) == 0) p.p2x = p.p1x;
    if ($urandom_range(0, 15) == 0) p.p2y = p.p1y;
    return p;
  endfunction

  function automatic pair_t make_pair(longint p1x, longint p1y, longint v1x, longint v1y,
                                      longint r1, longint m1, longint p2x, longint p2y,
                                      longint v2x, longint v2y, longint r2, longint m2);
    pair_t p;
    p = '{POS_W'(p1x), POS_W'(p1y), POS_W'(v1x), POS_W'(v1y), RAD_W'(r1), MASS_W'(m1),
          POS_W'(p2x), POS_W'(p2y), POS_W'(v2x), POS_W'(v2y), RAD_W'(r2), MASS_W'(m2)};
    return p;
  endfunction

  task automatic add_row(pair_t p, bit lit, res_t r);
    row_t row;
    row.pair    = p;
    row.literal = lit;
    row.res     = r;
    rows.push_back(row);
  endtask

  // Offer one pair and hold it until accepted; drop valid only while idle
  task automatic send_pair(pair_t p, res_t expected);
    while (($urandom_range(0, 99) < send_idle_pct)) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.first_pos_x   <= p.p1x;
    in_if.first_pos_y   <= p.p1y;
    in_if.first_vel_x   <= p.v1x;
    in_if.first_vel_y   <= p.v1y;
    in_if.first_radius  <= p.r1;
    in_if.first_mass    <= p.m1;
    in_if.second_pos_x  <= p.p2x;
    in_if.second_pos_y  <= p.p2y;
    in_if.second_vel_x  <= p.v2x;
    in_if.second_vel_y  <= p.v2y;
    in_if.second_radius <= p.r2;
    in_if.second_mass   <= p.m2;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    collision_results_q.push_back(expected);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (collision_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls plus a requested long hold-off
  initial begin
    out_if.ready <= 1'b0;
    hold_off = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off) begin
        hold_off = 1'b1;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (collision_results_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        res_t e;
        e = collision_results_q.pop_front();
        if (out_if.collided !== e.collided) begin
          $error("collided exp %0d got %0d", e.collided, out_if.collided); errors++;
        end
        if (out_if.new_first_pos_x !== e.new_first_pos_x) begin
          $error("new_first_pos_x exp %0d got %0d", e.new_first_pos_x,
                 out_if.new_first_pos_x); errors++;
        end
        if (out_if.new_first_pos_y !== e.new_first_pos_y) begin
          $error("new_first_pos_y exp %0d got %0d", e.new_first_pos_y,
                 out_if.new_first_pos_y); errors++;
        end
        if (out_if.new_first_vel_x !== e.new_first_vel_x) begin
          $error("new_first_vel_x exp %0d got %0d", e.new_first_vel_x,
                 out_if.new_first_vel_x); errors++;
        end
        if (out_if.new_first_vel_y !== e.new_first_vel_y) begin
          $error("new_first_vel_y exp %0d got %0d", e.new_first_vel_y,
                 out_if.new_first_vel_y); errors++;
        end
        if (out_if.new_second_pos_x !== e.new_second_pos_x) begin
          $error("new_second_pos_x exp %0d got %0d", e.new_second_pos_x,
                 out_if.new_second_pos_x); errors++;
        end
        if (out_if.new_second_pos_y !== e.new_second_pos_y) begin
          $error("new_second_pos_y exp %0d got %0d", e.new_second_pos_y,
                 out_if.new_second_pos_y); errors++;
        end
        if (out_if.new_second_vel_x !== e.new_second_vel_x) begin
          $error("new_second_vel_x exp %0d got %0d", e.new_second_vel_x,
                 out_if.new_second_vel_x); errors++;
        end
        if (out_if.new_second_vel_y !== e.new_second_vel_y) begin
          $error("new_second_vel_y exp %0d got %0d", e.new_second_vel_y,
                 out_if.new_second_vel_y); errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    pair_t p;
    res_t  r;
    errors         = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;
    r              = '0;
    rst_ni         = 1'b0;
    in_if.valid         <= 1'b0;
    in_if.first_pos_x   <= '0;
    in_if.first_pos_y   <= '0;
    in_if.first_vel_x   <= '0;
    in_if.first_vel_y   <= '0;
    in_if.first_radius  <= '0;
    in_if.first_mass    <= '0;
    in_if.second_pos_x  <= '0;
    in_if.second_pos_y  <= '0;
    in_if.second_vel_x  <= '0;
    in_if.second_vel_y  <= '0;
    in_if.second_radius <= '0;
    in_if.second_mass   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni = 1'b1;

    // Far apart pairs, one at the extremes: echo with flag clear
    p = make_pair(-8388608, -8388608, 8388607, -8388608, 0, 1,
                  8388607, 8388607, -8388608, 8388607, 0, 65535);
    add_row(p, 1'b1, '{1'b0, POS_MIN, POS_MIN, POS_MAX, POS_MIN,
                       POS_MAX, POS_MAX, POS_MIN, POS_MAX});
    p = make_pair(0, 0, 5, 6, 10, 3, 1000, 0, 7, 8, 10, 4);
    add_row(p, 1'b1, '{1'b0, 24'sd0, 24'sd0, 24'sd5, 24'sd6,
                       24'sd1000, 24'sd0, 24'sd7, 24'sd8});
    // Coincident centers, zero radii: touching, zero overlap
    p = make_pair(100, 100, 0, 0, 0, 1, 100, 100, 0, 0, 0, 1);
    add_row(p, 1'b1, '{1'b1, 24'sd100, 24'sd100, 24'sd0, 24'sd0,
                       24'sd100, 24'sd100, 24'sd0, 24'sd0});
    // Coincident centers with overlap and motion
    add_row(make_pair(0, 0, 256, 0, 512, 1, 0, 0, -256, 0, 512, 1), 1'b0, r);
    // Equal masses head-on: swap
    add_row(make_pair(0, 0, 256, 0, 256, 5, 512, 0, -256, 0, 256, 5), 1'b0, r);
    // Both masses zero: normal velocity kept
    add_row(make_pair(0, 0, 300, 40, 300, 0, 400, 300, -20, 9, 300, 0), 1'b0, r);
    // One mass zero rebounds
    add_row(make_pair(0, 0, 1000, 0, 600, 0, 900, 0, 0, 0, 600, 65535), 1'b0, r);
    add_row(make_pair(0, 0, 0, 0, 600, 65535, 0, 900, 0, -1000, 600, 0), 1'b0, r);
    // Max radii, saturation near the edges
    add_row(make_pair(8388607, 8388607, 8388607, 8388607, 1048575, 1,
                      8388000, 8388000, -8388608, -8388608, 1048575, 65535), 1'b0, r);
    add_row(make_pair(-8388608, -8388608, -8388608, 8388607, 1048575, 65535,
                      -8388000, -8388608, 8388607, -8388608, 1048575, 65535), 1'b0, r);
    add_row(make_pair(-8388608, 0, 8388607, 8388607, 1048575, 1,
                      -8388608, 1, 8388607, -8388608, 1048575, 1), 1'b0, r);
    // Diagonal contact
    add_row(make_pair(-300, 200, 77, -55, 400, 3, 100, -100, -33, 12, 200, 9), 1'b0, r);
    // Just touching and just missing
    add_row(make_pair(0, 0, 10, 10, 300, 2, 0, 500, -10, 4, 200, 2), 1'b0, r);
    add_row(make_pair(0, 0, 10, 10, 300, 2, 0, 501, -10, 4, 200, 2), 1'b0, r);

    foreach (rows[i]) begin
      send_pair(rows[i].pair,
                rows[i].literal ? rows[i].res : resolve_collision(rows[i].pair));
    end
    wait_drain();

    // Random phases with different idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        // Long receiver hold-off while pairs keep coming
        if (ph == 0 && n == 50) hold_off_req = 1'b1;
        if (ph == 0 && n == 60) hold_off_req = 1'b0;
        p = rand_pair();
        send_pair(p, resolve_collision(p));
      end
      // Sender pauses until everything has come back
      wait_drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0 && collision_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== circle_pair_elastic_collision.f =====
rtl/cpe_pkg.sv
rtl/cpe_if.sv
rtl/cpe_sqrt.sv
rtl/cpe_div.sv
rtl/circle_pair_elastic_collision.sv
tb/tb_circle_pair_elastic_collision.sv
